FILE: sv/mpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

    localparam int unsigned CH_MAX_W    = 5;   // enough for up to 32 channels
    localparam int unsigned FREQ_W      = 24;
    localparam int unsigned RPM_W       = 26;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned CFG_W       = 32;
    localparam int unsigned MAX_RESULTS = 12;
    localparam int unsigned RES_CNT_W   = 4;

    localparam logic [FREQ_W-1:0] FREQ_SCALE    = 24'd10000000;
    localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 32'd12000000;

    typedef enum logic {
        K_TICK = 1'b0,
        K_EDGE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CH_MAX_W-1:0]  channel;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/multichannel_period_tachometer_core.sv
// Edge request: the 24-step divider gives the frequency for the result register.
// Tick request: S_MASK takes the stale channels, then S_TICK_OUT gives one result each.
// Requests are worked one at a time; a two-entry queue takes new requests meanwhile.
// Reset (synchronous, active low) clears the clock, all channel times and active flags,
// empties the queue and result register, and sets timeout_us to 12000000.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_period_tachometer_core #(
    parameter int unsigned NUM_CHANNELS = 12,
    parameter int unsigned TIME_WIDTH   = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [mpt_pkg::CFG_W-1:0]     i_cfg_timeout_us,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_req_type,
    input  wire  [mpt_pkg::IDX_W-1:0]     i_channel,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [mpt_pkg::IDX_W-1:0]     o_sensor_index,
    output logic [mpt_pkg::FREQ_W-1:0]    o_scaled_freq,
    output logic [mpt_pkg::RPM_W-1:0]     o_rpm,
    output logic                          o_timed_out,
    output logic                          o_last
);

    logic [mpt_pkg::CFG_W-1:0] r_timeout_us;
    logic                      w_cmd_valid;
    mpt_pkg::t_cmd             w_cmd;
    logic                      w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us <= mpt_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout_us <= i_cfg_timeout_us;
        end
    end

    mpt_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_channel   (i_channel),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    mpt_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .i_timeout_us   (r_timeout_us),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sensor_index (o_sensor_index),
        .o_scaled_freq  (o_scaled_freq),
        .o_rpm          (o_rpm),
        .o_timed_out    (o_timed_out),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

FILE: sv/mpt_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Accepts requests, drops edges on channels that do not exist, and queues the rest.
module mpt_front #(
    parameter int unsigned NUM_CHANNELS = 12
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire                         i_req_type,
    input  wire  [mpt_pkg::IDX_W-1:0]   i_channel,
    output logic                        o_cmd_valid,
    output mpt_pkg::t_cmd               o_cmd,
    input  wire                         i_cmd_pop
);

    logic [1:0]        r_count;
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    mpt_pkg::t_cmd     r_queue [2];

    logic              w_accept;
    logic              w_keep;
    logic              w_push;
    logic              w_pop;
    mpt_pkg::t_cmd     w_cmd;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_cmd.kind    = i_req_type ? mpt_pkg::K_EDGE : mpt_pkg::K_TICK;
        w_cmd.channel = mpt_pkg::CH_MAX_W'(i_channel);
        // an edge beyond the last channel has no effect at all
        w_keep = !i_req_type || ({2'b00, i_channel} < 6'(NUM_CHANNELS));
    end

    assign w_push = w_accept && w_keep;
    assign w_pop  = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mpt_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider: FREQ_SCALE / divisor, one quotient bit per cycle.
module mpt_div #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [TIME_WIDTH-1:0]        i_divisor,
    output logic                         o_done,
    output logic [mpt_pkg::FREQ_W-1:0]   o_quotient
);

    localparam int unsigned QW  = mpt_pkg::FREQ_W;
    localparam int unsigned CTW = $clog2(QW);

    logic [TIME_WIDTH:0]   r_rem;
    logic [TIME_WIDTH-1:0] r_dvs;
    logic [QW-1:0]         r_quo;
    logic [CTW-1:0]        r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [TIME_WIDTH:0]   w_shift;
    logic [TIME_WIDTH:0]   w_diff;
    logic                  w_bit;

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        w_shift = {r_rem[TIME_WIDTH-1:0], r_quo[QW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_bit   = (w_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CTW'(QW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CTW'(1);
                if (r_cnt == CTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= mpt_pkg::FREQ_SCALE;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff : w_shift;
            r_quo <= {r_quo[QW-2:0], w_bit};
        end
    end

endmodule

`default_nettype wire

FILE: sv/mpt_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Executes queued requests: channel state, timeout scan and the result register.
module mpt_back #(
    parameter int unsigned NUM_CHANNELS = 12,
    parameter int unsigned TIME_WIDTH   = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cmd_valid,
    input  mpt_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    input  wire  [mpt_pkg::CFG_W-1:0]     i_timeout_us,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [mpt_pkg::IDX_W-1:0]     o_sensor_index,
    output logic [mpt_pkg::FREQ_W-1:0]    o_scaled_freq,
    output logic [mpt_pkg::RPM_W-1:0]     o_rpm,
    output logic                          o_timed_out,
    output logic                          o_last
);

    localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned CW   = (TIME_WIDTH > mpt_pkg::CFG_W) ? TIME_WIDTH
                                                                 : mpt_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_EDGE_OUT,
        S_MASK,
        S_TICK_OUT
    } t_state;

    t_state                          r_state;
    logic [TIME_WIDTH-1:0]           r_now;
    logic [TIME_WIDTH-1:0]           r_edge_time [NUM_CHANNELS];
    logic [TIME_WIDTH-1:0]           r_upd_time  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]         r_active;
    logic [NUM_CHANNELS-1:0]         r_mask;
    logic [CH_W-1:0]                 r_ch;
    logic [mpt_pkg::FREQ_W-1:0]      r_freq;
    logic [mpt_pkg::RES_CNT_W-1:0]   r_res_cnt;

    logic                            r_out_valid;
    logic [mpt_pkg::IDX_W-1:0]       r_sensor_index;
    logic [mpt_pkg::FREQ_W-1:0]      r_scaled_freq;
    logic [mpt_pkg::RPM_W-1:0]       r_rpm;
    logic                            r_timed_out;
    logic                            r_last;

    logic [CH_W-1:0]                 w_cmd_ch;
    logic [TIME_WIDTH-1:0]           w_interval;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [mpt_pkg::FREQ_W-1:0]      w_quotient;
    logic [mpt_pkg::RPM_W-1:0]       w_rpm;
    logic                            w_out_free;
    logic                            w_out_load;
    logic [NUM_CHANNELS-1:0]         w_stale;
    logic [CH_W-1:0]                 w_low_idx;
    logic [NUM_CHANNELS-1:0]         w_rest;
    logic                            w_tick_last;
    logic [TIME_WIDTH-1:0]           w_elapsed [NUM_CHANNELS];

    assign w_cmd_ch   = i_cmd.channel[CH_W-1:0];
    assign w_interval = r_now - r_edge_time[w_cmd_ch];
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = w_out_free && ((r_state == S_EDGE_OUT)
                        || ((r_state == S_TICK_OUT) && (r_mask != '0)));
    assign o_cmd_pop  = (r_state == S_IDLE);
    assign w_div_start = (r_state == S_IDLE) && i_cmd_valid
                         && (i_cmd.kind == mpt_pkg::K_EDGE) && (w_interval != '0);

    // rpm = 4*f + 2*f
    assign w_rpm = (mpt_pkg::RPM_W'(r_freq) << 2) + (mpt_pkg::RPM_W'(r_freq) << 1);

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            w_elapsed[i] = r_now - r_upd_time[i];
            w_stale[i]   = r_active[i]
                           && (CW'(w_elapsed[i]) > CW'(i_timeout_us));
        end
    end

    always_comb begin
        w_low_idx = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_low_idx = CH_W'(i);
            end
        end
        w_rest      = r_mask & ~(NUM_CHANNELS'(1) << w_low_idx);
        w_tick_last = (w_rest == '0)
                      || (r_res_cnt == mpt_pkg::RES_CNT_W'(mpt_pkg::MAX_RESULTS - 1));
    end

    mpt_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (w_interval),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
            r_res_cnt   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_edge_time[i] <= '0;
                r_upd_time[i]  <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.kind == mpt_pkg::K_EDGE) begin
                            r_edge_time[w_cmd_ch] <= r_now;
                            r_ch                  <= w_cmd_ch;
                            if (w_interval != '0) begin
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_now   <= r_now + TIME_WIDTH'(1);
                            r_state <= S_MASK;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_freq  <= w_quotient;
                        r_state <= S_EDGE_OUT;
                    end
                end
                S_EDGE_OUT: begin
                    if (w_out_free) begin
                        r_out_valid        <= 1'b1;
                        r_sensor_index     <= mpt_pkg::IDX_W'(r_ch);
                        r_scaled_freq      <= r_freq;
                        r_rpm              <= w_rpm;
                        r_timed_out        <= 1'b0;
                        r_last             <= 1'b1;
                        r_active[r_ch]     <= (r_freq != '0);
                        r_upd_time[r_ch]   <= r_now;
                        r_state            <= S_IDLE;
                    end
                end
                S_MASK: begin
                    r_mask    <= w_stale;
                    r_res_cnt <= '0;
                    r_state   <= S_TICK_OUT;
                end
                S_TICK_OUT: begin
                    if (r_mask == '0) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid           <= 1'b1;
                        r_sensor_index        <= mpt_pkg::IDX_W'(w_low_idx);
                        r_scaled_freq         <= '0;
                        r_rpm                 <= '0;
                        r_timed_out           <= 1'b1;
                        r_last                <= w_tick_last;
                        r_active[w_low_idx]   <= 1'b0;
                        r_upd_time[w_low_idx] <= r_now;
                        r_mask                <= w_rest;
                        r_res_cnt             <= r_res_cnt + mpt_pkg::RES_CNT_W'(1);
                        if (w_tick_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sensor_index = r_sensor_index;
    assign o_scaled_freq  = r_scaled_freq;
    assign o_rpm          = r_rpm;
    assign o_timed_out    = r_timed_out;
    assign o_last         = r_last;

endmodule

`default_nettype wire

FILE: verif/tb_multichannel_period_tachometer_core.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [mpt_pkg::IDX_W-1:0]  sensor;
    logic [mpt_pkg::FREQ_W-1:0] freq;
    logic [mpt_pkg::RPM_W-1:0]  rpm;
    logic                       timed_out;
    logic                       last;
} t_reading;

class rpm_scoreboard;
    localparam int unsigned NUM_CH     = 12;
    localparam int unsigned RPM_FACTOR = 6;

    bit [mpt_pkg::CFG_W-1:0] timeout_us;
    bit [31:0]      now_us;
    bit [31:0]      edge_time[NUM_CH];
    bit [31:0]      update_time[NUM_CH];
    bit             active[NUM_CH];
    t_reading       readings_due[$];
    int             n_mismatch;

    function new();
        timeout_us = mpt_pkg::TIMEOUT_RESET;
        now_us     = '0;
        n_mismatch = 0;
        for (int i = 0; i < NUM_CH; i++) begin
            edge_time[i]   = '0;
            update_time[i] = '0;
            active[i]      = 1'b0;
        end
    endfunction

    function void set_timeout(bit [mpt_pkg::CFG_W-1:0] value);
        timeout_us = value;
    endfunction

    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_mismatch++;
    endtask

    // Work out the readings one accepted request causes.
    function void note_request(mpt_pkg::t_kind kind, logic [mpt_pkg::IDX_W-1:0] ch);
        bit [31:0] interval;
        bit [31:0] quot;
        bit [31:0] scaled;
        int        count;
        t_reading  r;
        count = 0;
        case (kind)
            mpt_pkg::K_EDGE: begin
                if (ch < NUM_CH) begin
                    interval      = now_us - edge_time[ch];
                    edge_time[ch] = now_us;
                    if (interval != 0) begin
                        quot            = 32'(mpt_pkg::FREQ_SCALE) / interval;
                        scaled          = quot * RPM_FACTOR;
                        active[ch]      = (scaled != 0);
                        update_time[ch] = now_us;
                        r.sensor    = ch;
                        r.freq      = quot[mpt_pkg::FREQ_W-1:0];
                        r.rpm       = scaled[mpt_pkg::RPM_W-1:0];
                        r.timed_out = 1'b0;
                        r.last      = 1'b1;
                        readings_due.push_back(r);
                    end
                end
            end
            default: begin
                now_us = now_us + 1;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (active[i] && count < mpt_pkg::MAX_RESULTS &&
                        (now_us - update_time[i]) > timeout_us) begin
                        active[i]      = 1'b0;
                        update_time[i] = now_us;
                        r.sensor    = mpt_pkg::IDX_W'(i);
                        r.freq      = '0;
                        r.rpm       = '0;
                        r.timed_out = 1'b1;
                        r.last      = 1'b0;
                        readings_due.push_back(r);
                        count++;
                    end
                end
                if (count > 0) begin
                    r = readings_due.pop_back();
                    r.last = 1'b1;
                    readings_due.push_back(r);
                end
            end
        endcase
    endfunction

    task check_reading(t_reading got);
        t_reading want;
        if (readings_due.size() == 0) begin
            report_mismatch($sformatf("unexpected reading for sensor %0d", got.sensor));
            return;
        end
        want = readings_due.pop_front();
        if (got.sensor != want.sensor)
            report_mismatch($sformatf("sensor_index %0d, want %0d", got.sensor, want.sensor));
        if (got.freq != want.freq)
            report_mismatch($sformatf("scaled_freq %0d, want %0d (sensor %0d)",
                                      got.freq, want.freq, want.sensor));
        if (got.rpm != want.rpm)
            report_mismatch($sformatf("rpm %0d, want %0d (sensor %0d)",
                                      got.rpm, want.rpm, want.sensor));
        if (got.timed_out != want.timed_out)
            report_mismatch($sformatf("timed_out %0b, want %0b (sensor %0d)",
                                      got.timed_out, want.timed_out, want.sensor));
        if (got.last != want.last)
            report_mismatch($sformatf("last %0b, want %0b (sensor %0d)",
                                      got.last, want.last, want.sensor));
    endtask
endclass

module tb_multichannel_period_tachometer_core;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned HOLD_CYCLES    = 300;

    logic                          i_clk      = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_valid  = 1'b0;
    logic [mpt_pkg::CFG_W-1:0]     cfg_data   = '0;
    logic                          in_valid   = 1'b0;
    logic                          req_type   = 1'b0;
    logic [mpt_pkg::IDX_W-1:0]     channel    = '0;
    logic                          out_ready  = 1'b0;

    wire                           o_cfg_ready;
    wire                           o_in_ready;
    wire                           o_out_valid;
    wire  [mpt_pkg::IDX_W-1:0]     o_sensor_index;
    wire  [mpt_pkg::FREQ_W-1:0]    o_scaled_freq;
    wire  [mpt_pkg::RPM_W-1:0]     o_rpm;
    wire                           o_timed_out;
    wire                           o_last;

    bit                 hold_req = 1'b0;
    bit                 no_idle  = 1'b0;
    int unsigned        idle_cycles = 0;

    rpm_scoreboard sb = new();

    multichannel_period_tachometer_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_timeout_us (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (req_type),
        .i_channel        (channel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_sensor_index   (o_sensor_index),
        .o_scaled_freq    (o_scaled_freq),
        .o_rpm            (o_rpm),
        .o_timed_out      (o_timed_out),
        .o_last           (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(input mpt_pkg::t_kind kind,
                            input logic [mpt_pkg::IDX_W-1:0] ch);
        int gap;
        @(negedge i_clk);
        in_valid <= 1'b1;
        req_type <= kind;
        channel  <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(kind, ch);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_req(mpt_pkg::K_TICK, mpt_pkg::IDX_W'($urandom_range(0, 15)));
    endtask

    // stop sending and let every reading come out, plus in-flight ticks
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.readings_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [mpt_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_timeout(value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int r;
        int run;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                run = $urandom_range(1, 24);
                if (run > n_items - sent)
                    run = n_items - sent;
                repeat (run) send_tick();
                sent += run;
            end else if (r < 92) begin
                send_req(mpt_pkg::K_EDGE, mpt_pkg::IDX_W'($urandom_range(0, 11)));
                sent++;
            end else begin
                // channels past the last one are dropped by the block
                send_req(mpt_pkg::K_EDGE, mpt_pkg::IDX_W'($urandom_range(12, 15)));
                sent++;
            end
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (no_idle)
                stall = 0;
            else
                stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready)
            sb.check_reading('{o_sensor_index, o_scaled_freq, o_rpm, o_timed_out, o_last});
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [mpt_pkg::CFG_W-1:0] phase_timeout[6];
        phase_timeout[0] = 32'hFFFF_FFFF;
        phase_timeout[1] = $urandom_range(1, 6);
        phase_timeout[2] = $urandom_range(1, 40);
        phase_timeout[3] = mpt_pkg::TIMEOUT_RESET;
        phase_timeout[4] = $urandom_range(20, 300);
        phase_timeout[5] = 1;

        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;

        // first edge at time zero has no interval; then the fastest reading
        send_req(mpt_pkg::K_EDGE, 4'd0);
        send_req(mpt_pkg::K_EDGE, 4'd15);
        send_req(mpt_pkg::K_EDGE, 4'd12);
        send_tick();
        send_req(mpt_pkg::K_EDGE, 4'd0);
        send_req(mpt_pkg::K_EDGE, 4'd0);
        send_tick();
        send_tick();
        send_req(mpt_pkg::K_EDGE, 4'd0);
        send_req(mpt_pkg::K_EDGE, 4'd11);
        drain();

        // bring all channels up at one time stamp so they all go stale on one tick
        write_timeout(32'd1);
        for (int c = 1; c <= 10; c++)
            send_req(mpt_pkg::K_EDGE, mpt_pkg::IDX_W'(c));
        send_req(mpt_pkg::K_EDGE, 4'd0);
        send_req(mpt_pkg::K_EDGE, 4'd11);
        send_tick();
        send_tick();

        for (int p = 0; p < 6; p++) begin
            drain();
            write_timeout(phase_timeout[p]);
            if (p == 2) begin
                // output stalled for a long time while requests keep coming
                hold_req = 1'b1;
                no_idle  = 1'b1;
                repeat (16) begin
                    send_tick();
                    send_req(mpt_pkg::K_EDGE, mpt_pkg::IDX_W'($urandom_range(0, 11)));
                end
                no_idle = 1'b0;
                random_phase(20);
            end else if (p == 4) begin
                no_idle = 1'b1;
                random_phase(45);
                no_idle = 1'b0;
            end else begin
                random_phase(50);
            end
        end

        drain();
        if (sb.n_mismatch == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
